// ===== design/hsdt_pkg.sv =====
// Package for the heater SSR duty timer: request/response words, codes,
// sequencer states and fixed constants. No dependencies.
`default_nettype none
package hsdt_pkg;

   localparam int DEF_LOG_DEPTH = 32;
   localparam int DIVIDEND_W    = 26;
   localparam int DIVISOR_W     = 10;
   localparam int LOG_COUNT_W   = 6;
   localparam int LOG_IDX_W     = 5;
   localparam int CSR_W         = 16;

   localparam logic [15:0] ON_TIME_RESET       = 16'd1000;
   localparam logic [15:0] SAMPLE_GAP_RESET    = 16'd250;
   localparam logic [9:0]  FULL_DUTY           = 10'd990;
   localparam logic [9:0]  MIN_DUTY            = 10'd10;
   localparam logic [9:0]  MAX_DUTY            = 10'd1000;
   localparam logic [9:0]  MS_SCALE            = 10'd1000;
   localparam logic [31:0] IDLE_OFF_MS         = 32'd10000;
   localparam logic [31:0] LOG_GAP_MS          = 32'd15000;

   typedef enum logic [1:0] {
      REQ_TICK       = 2'd0,
      REQ_ACTIVATE   = 2'd1,
      REQ_DEACTIVATE = 2'd2,
      REQ_CLEAR_LOG  = 2'd3
   } req_kind_type;

   typedef enum logic [0:0] {
      CSR_ON_TIME    = 1'b0,
      CSR_SAMPLE_GAP = 1'b1
   } csr_idx_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_READ,
      ST_LOG,
      ST_EXPIRE,
      ST_RELAY,
      ST_MUL,
      ST_DIV,
      ST_OFF,
      ST_OUT
   } seq_state_type;

   typedef struct packed {
      logic [1:0]  req_type;
      logic [31:0] time_ms;
      logic [11:0] temp_sample;
      logic [9:0]  duty_permille;
      logic [31:0] shutoff_ms;
   } req_word_type;

   typedef struct packed {
      logic        ssr_on;
      logic        heater_on;
      logic [11:0] latched_temp;
      logic        log_valid;
      logic [4:0]  log_index;
      logic [11:0] log_temp;
      logic [31:0] log_elapsed_ms;
      logic        auto_shutoff;
   } rsp_word_type;

   typedef struct packed {
      logic [31:0] a;
      logic [31:0] b;
      logic [31:0] c;
   } alu_op_type;

   typedef struct packed {
      logic [31:0] diff;
      logic        ge;
   } alu_res_type;

   typedef struct packed {
      logic                  start;
      logic [DIVIDEND_W-1:0] dividend;
      logic [DIVISOR_W-1:0]  divisor;
   } div_ctl_type;

   typedef struct packed {
      logic                  done;
      logic [DIVIDEND_W-1:0] quot;
   } div_stat_type;

endpackage
`default_nettype wire

// ===== design/hsdt_alu.sv =====
// Shared wrapping subtract and compare unit of the duty timer sequencer.
// Depends on hsdt_pkg.
`default_nettype none
module hsdt_alu (
   input  hsdt_pkg::alu_op_type  op,
   output hsdt_pkg::alu_res_type res
);

   logic [31:0] diff;

   assign diff     = op.a - op.b;
   assign res.diff = diff;
   assign res.ge   = (diff >= op.c);

endmodule
`default_nettype wire

// ===== design/hsdt_div.sv =====
// Restoring divider, one quotient bit per cycle, for the relay off time.
// Depends on hsdt_pkg.
`default_nettype none
module hsdt_div (
   input  logic                   clock,
   input  logic                   reset,
   input  hsdt_pkg::div_ctl_type  ctl,
   output hsdt_pkg::div_stat_type stat
);

   localparam int DW = hsdt_pkg::DIVIDEND_W;
   localparam int VW = hsdt_pkg::DIVISOR_W;
   localparam int CW = $clog2(DW + 1);

   logic          busy_ff, busy_in;
   logic          done_ff, done_in;
   logic [CW-1:0] count_ff, count_in;
   logic [VW-1:0] rem_ff, rem_in;
   logic [VW-1:0] divisor_ff, divisor_in;
   logic [DW-1:0] quot_ff, quot_in;
   logic [VW:0]   shifted;
   logic          fits;

   assign shifted = {rem_ff, quot_ff[DW-1]};
   assign fits    = (shifted >= {1'b0, divisor_ff});

   always_comb begin
      busy_in    = busy_ff;
      done_in    = 1'b0;
      count_in   = count_ff;
      rem_in     = rem_ff;
      divisor_in = divisor_ff;
      quot_in    = quot_ff;
      if (ctl.start) begin
         busy_in    = 1'b1;
         count_in   = CW'(DW);
         rem_in     = '0;
         divisor_in = ctl.divisor;
         quot_in    = ctl.dividend;
      end else if (busy_ff) begin
         // shift in the next dividend bit, subtract when it fits
         rem_in   = fits ? VW'(shifted - {1'b0, divisor_ff}) : shifted[VW-1:0];
         quot_in  = {quot_ff[DW-2:0], fits};
         count_in = count_ff - CW'(1);
         if (count_ff == CW'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff  <= 1'b0;
         done_ff  <= 1'b0;
         count_ff <= '0;
      end else begin
         busy_ff  <= busy_in;
         done_ff  <= done_in;
         count_ff <= count_in;
      end
      rem_ff     <= rem_in;
      divisor_ff <= divisor_in;
      quot_ff    <= quot_in;
   end

   assign stat.done = done_ff;
   assign stat.quot = quot_ff;

endmodule
`default_nettype wire

// ===== design/heater_ssr_duty_timer_core.sv =====
// Top level of the heater SSR duty timer: sequencer, state and output word.
// Depends on hsdt_pkg, hsdt_alu and hsdt_div.
//
//   channel  ports                         direction  handshake
//   req      req_valid req_stall req_data  in         valid / stall
//   rsp      rsp_valid rsp_stall rsp_data  out        valid / stall
//   csr      csr_we csr_index csr_wdata    in         write enable only
//
// Tick: read, log, expire and relay checks on the shared subtractor, then output;
// log and relay checks may be skipped. Activate: division (26 divider steps) when the duty needs it.
// Deactivate and clear log go straight to output. A result waits while rsp_stall holds the output.
// req_stall is high while an item is in work; the output register lets the
// next word be taken while a finished word is still stalled.
// Reset is synchronous and clears all control and timer state.
`default_nettype none
module heater_ssr_duty_timer_core #(
   parameter int LOG_DEPTH = hsdt_pkg::DEF_LOG_DEPTH
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   output logic                       req_stall,
   input  hsdt_pkg::req_word_type     req_data,
   output logic                       rsp_valid,
   input  logic                       rsp_stall,
   output hsdt_pkg::rsp_word_type     rsp_data,
   input  logic                       csr_we,
   input  logic                       csr_index,
   input  logic [hsdt_pkg::CSR_W-1:0] csr_wdata
);

   localparam int LCW = hsdt_pkg::LOG_COUNT_W;

   hsdt_pkg::seq_state_type state_ff, state_in;
   hsdt_pkg::req_word_type  cur_ff, cur_in;
   hsdt_pkg::rsp_word_type  rsp_ff, rsp_in;
   hsdt_pkg::alu_op_type    alu_op;
   hsdt_pkg::alu_res_type   alu_res;
   hsdt_pkg::div_ctl_type   div_ctl;
   hsdt_pkg::div_stat_type  div_stat;

   logic            rsp_valid_ff, rsp_valid_in;
   logic [15:0]     on_time_ff, on_time_in;
   logic [15:0]     read_ivl_ff, read_ivl_in;
   logic [11:0]     temp_hold_ff, temp_hold_in;
   logic [31:0]     last_read_ff, last_read_in;
   logic            relay_ff, relay_in;
   logic [31:0]     last_toggle_ff, last_toggle_in;
   logic [31:0]     off_time_ff, off_time_in;
   logic [9:0]      duty_hold_ff, duty_hold_in;
   logic            heater_ff, heater_in;
   logic [31:0]     start_time_ff, start_time_in;
   logic [31:0]     run_length_ff, run_length_in;
   logic [LCW-1:0]  log_count_ff, log_count_in;
   logic [31:0]     last_log_ff, last_log_in;
   logic            logged_ff, logged_in;
   logic [4:0]      log_idx_ff, log_idx_in;
   logic [11:0]     log_temp_ff, log_temp_in;
   logic [31:0]     log_elapsed_ff, log_elapsed_in;
   logic            expired_ff, expired_in;
   logic [9:0]      duty_clamp;
   logic            log_room;
   logic            req_take;
   logic            rsp_free;

   hsdt_alu u_alu (
      .op  (alu_op),
      .res (alu_res)
   );

   hsdt_div u_div (
      .clock (clock),
      .reset (reset),
      .ctl   (div_ctl),
      .stat  (div_stat)
   );

   assign req_stall  = (state_ff != hsdt_pkg::ST_IDLE);
   assign req_take   = req_valid && !req_stall;
   assign rsp_free   = !rsp_valid_ff || !rsp_stall;
   assign duty_clamp = (cur_ff.duty_permille > hsdt_pkg::MAX_DUTY) ?
                       hsdt_pkg::MAX_DUTY : cur_ff.duty_permille;
   assign log_room   = (log_count_ff < LCW'(LOG_DEPTH));

   // operand select for the shared subtractor
   always_comb begin
      alu_op = '0;
      unique case (state_ff)
         hsdt_pkg::ST_READ:   alu_op = '{a: cur_ff.time_ms, b: last_read_ff,
                                         c: {16'b0, read_ivl_ff}};
         hsdt_pkg::ST_LOG:    alu_op = '{a: cur_ff.time_ms, b: last_log_ff,
                                         c: hsdt_pkg::LOG_GAP_MS};
         hsdt_pkg::ST_EXPIRE: alu_op = '{a: cur_ff.time_ms, b: start_time_ff,
                                         c: run_length_ff};
         hsdt_pkg::ST_RELAY:  alu_op = '{a: cur_ff.time_ms, b: last_toggle_ff,
                                         c: relay_ff ? {16'b0, on_time_ff} : off_time_ff};
         hsdt_pkg::ST_OFF:    alu_op = '{a: {6'b0, div_stat.quot}, b: {16'b0, on_time_ff},
                                         c: 32'b0};
         default:             alu_op = '0;
      endcase
   end

   always_comb begin
      state_in       = state_ff;
      cur_in         = cur_ff;
      rsp_in         = rsp_ff;
      rsp_valid_in   = rsp_valid_ff && rsp_stall;
      on_time_in     = on_time_ff;
      read_ivl_in    = read_ivl_ff;
      temp_hold_in   = temp_hold_ff;
      last_read_in   = last_read_ff;
      relay_in       = relay_ff;
      last_toggle_in = last_toggle_ff;
      off_time_in    = off_time_ff;
      duty_hold_in   = duty_hold_ff;
      heater_in      = heater_ff;
      start_time_in  = start_time_ff;
      run_length_in  = run_length_ff;
      log_count_in   = log_count_ff;
      last_log_in    = last_log_ff;
      logged_in      = logged_ff;
      log_idx_in     = log_idx_ff;
      log_temp_in    = log_temp_ff;
      log_elapsed_in = log_elapsed_ff;
      expired_in     = expired_ff;
      div_ctl        = '{start: 1'b0,
                         dividend: hsdt_pkg::DIVIDEND_W'(on_time_ff) *
                                   hsdt_pkg::DIVIDEND_W'(hsdt_pkg::MS_SCALE),
                         divisor: duty_clamp};

      if (csr_we) begin
         unique case (hsdt_pkg::csr_idx_type'(csr_index))
            hsdt_pkg::CSR_ON_TIME:    on_time_in  = csr_wdata;
            hsdt_pkg::CSR_SAMPLE_GAP: read_ivl_in = csr_wdata;
            default: ;
         endcase
      end

      unique case (state_ff)
         hsdt_pkg::ST_IDLE: begin
            if (req_take) begin
               cur_in     = req_data;
               logged_in  = 1'b0;
               expired_in = 1'b0;
               unique case (hsdt_pkg::req_kind_type'(req_data.req_type))
                  hsdt_pkg::REQ_TICK:     state_in = hsdt_pkg::ST_READ;
                  hsdt_pkg::REQ_ACTIVATE: state_in = hsdt_pkg::ST_MUL;
                  hsdt_pkg::REQ_DEACTIVATE: begin
                     heater_in = 1'b0;
                     relay_in  = 1'b0;
                     state_in  = hsdt_pkg::ST_OUT;
                  end
                  hsdt_pkg::REQ_CLEAR_LOG: begin
                     log_count_in = '0;
                     state_in     = hsdt_pkg::ST_OUT;
                  end
                  default: state_in = hsdt_pkg::ST_OUT;
               endcase
            end
         end
         hsdt_pkg::ST_READ: begin
            state_in = hsdt_pkg::ST_EXPIRE;
            if (alu_res.ge) begin
               temp_hold_in = cur_ff.temp_sample;
               last_read_in = cur_ff.time_ms;
               if (heater_ff && log_room)
                  state_in = hsdt_pkg::ST_LOG;
            end
         end
         hsdt_pkg::ST_LOG: begin
            if (log_count_ff == '0 || alu_res.ge) begin
               logged_in    = 1'b1;
               log_idx_in   = log_count_ff[hsdt_pkg::LOG_IDX_W-1:0];
               log_temp_in  = cur_ff.temp_sample;
               last_log_in  = cur_ff.time_ms;
               log_count_in = log_count_ff + LCW'(1);
            end
            state_in = hsdt_pkg::ST_EXPIRE;
         end
         hsdt_pkg::ST_EXPIRE: begin
            log_elapsed_in = alu_res.diff;
            if (heater_ff && run_length_ff != '0 && alu_res.ge) begin
               heater_in  = 1'b0;
               relay_in   = 1'b0;
               expired_in = 1'b1;
               state_in   = hsdt_pkg::ST_OUT;
            end else if (heater_ff) begin
               state_in = hsdt_pkg::ST_RELAY;
            end else begin
               relay_in = 1'b0;
               state_in = hsdt_pkg::ST_OUT;
            end
         end
         hsdt_pkg::ST_RELAY: begin
            if (duty_hold_ff >= hsdt_pkg::FULL_DUTY) begin
               if (!relay_ff) begin
                  relay_in       = 1'b1;
                  last_toggle_in = cur_ff.time_ms;
               end
            end else if (alu_res.ge) begin
               relay_in       = !relay_ff;
               last_toggle_in = cur_ff.time_ms;
            end
            state_in = hsdt_pkg::ST_OUT;
         end
         hsdt_pkg::ST_MUL: begin
            duty_hold_in  = duty_clamp;
            heater_in     = 1'b1;
            start_time_in = cur_ff.time_ms;
            run_length_in = cur_ff.shutoff_ms;
            if (duty_clamp >= hsdt_pkg::FULL_DUTY) begin
               off_time_in = '0;
               state_in    = hsdt_pkg::ST_OUT;
            end else if (duty_clamp <= hsdt_pkg::MIN_DUTY) begin
               off_time_in = hsdt_pkg::IDLE_OFF_MS;
               state_in    = hsdt_pkg::ST_OUT;
            end else begin
               div_ctl.start = 1'b1;
               state_in      = hsdt_pkg::ST_DIV;
            end
         end
         hsdt_pkg::ST_DIV: begin
            if (div_stat.done)
               state_in = hsdt_pkg::ST_OFF;
         end
         hsdt_pkg::ST_OFF: begin
            off_time_in = alu_res.diff;
            state_in    = hsdt_pkg::ST_OUT;
         end
         hsdt_pkg::ST_OUT: begin
            // hold until the output register is free
            if (rsp_free) begin
               rsp_valid_in = 1'b1;
               rsp_in = '{ssr_on:         relay_ff,
                          heater_on:      heater_ff,
                          latched_temp:   temp_hold_ff,
                          log_valid:      logged_ff,
                          log_index:      logged_ff ? log_idx_ff : 5'b0,
                          log_temp:       logged_ff ? log_temp_ff : 12'b0,
                          log_elapsed_ms: logged_ff ? log_elapsed_ff : 32'b0,
                          auto_shutoff:   expired_ff};
               state_in = hsdt_pkg::ST_IDLE;
            end
         end
         default: state_in = hsdt_pkg::ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= hsdt_pkg::ST_IDLE;
         rsp_valid_ff   <= 1'b0;
         on_time_ff     <= hsdt_pkg::ON_TIME_RESET;
         read_ivl_ff    <= hsdt_pkg::SAMPLE_GAP_RESET;
         temp_hold_ff   <= '0;
         last_read_ff   <= '0;
         relay_ff       <= 1'b0;
         last_toggle_ff <= '0;
         off_time_ff    <= hsdt_pkg::IDLE_OFF_MS;
         duty_hold_ff   <= '0;
         heater_ff      <= 1'b0;
         start_time_ff  <= '0;
         run_length_ff  <= '0;
         log_count_ff   <= '0;
         last_log_ff    <= '0;
         logged_ff      <= 1'b0;
         expired_ff     <= 1'b0;
      end else begin
         state_ff       <= state_in;
         rsp_valid_ff   <= rsp_valid_in;
         on_time_ff     <= on_time_in;
         read_ivl_ff    <= read_ivl_in;
         temp_hold_ff   <= temp_hold_in;
         last_read_ff   <= last_read_in;
         relay_ff       <= relay_in;
         last_toggle_ff <= last_toggle_in;
         off_time_ff    <= off_time_in;
         duty_hold_ff   <= duty_hold_in;
         heater_ff      <= heater_in;
         start_time_ff  <= start_time_in;
         run_length_ff  <= run_length_in;
         log_count_ff   <= log_count_in;
         last_log_ff    <= last_log_in;
         logged_ff      <= logged_in;
         expired_ff     <= expired_in;
      end
      cur_ff         <= cur_in;
      rsp_ff         <= rsp_in;
      log_idx_ff     <= log_idx_in;
      log_temp_ff    <= log_temp_in;
      log_elapsed_ff <= log_elapsed_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

`ifndef SYNTHESIS
   a_relay_needs_heater: assert property (@(posedge clock) disable iff (reset)
      !heater_ff |-> !relay_ff)
      else $error("relay on while heater disabled");

   a_log_count_bound: assert property (@(posedge clock) disable iff (reset)
      log_count_ff <= LCW'(LOG_DEPTH))
      else $error("log count beyond log depth");

   a_shutoff_clears_heater: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_ff.auto_shutoff |-> !rsp_ff.heater_on && !rsp_ff.ssr_on)
      else $error("auto shutoff word shows heater or relay on");

   a_div_done_in_wait: assert property (@(posedge clock) disable iff (reset)
      div_stat.done |-> state_ff == hsdt_pkg::ST_DIV)
      else $error("divider finished outside its wait state");

   a_out_loads_word: assert property (@(posedge clock) disable iff (reset)
      state_ff == hsdt_pkg::ST_OUT && rsp_free |=> rsp_valid_ff)
      else $error("finished item produced no result word");
`endif

endmodule
`default_nettype wire
